// ===== sv/assert_macros.svh =====
// assertion macros shared by the inode cache modules
// no dependencies; bodies are empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== sv/icr_pkg.sv =====
// types and constants for the inode cache
// no dependencies
package icr_pkg;

	localparam int SLOTS            = 64;
	localparam int INODES_PER_BLOCK = 8;

	localparam int DEV_W   = 8;
	localparam int INODE_W = 24;
	localparam int SHARE_W = 8;
	localparam int CNT_W   = 32;
	localparam int BLK_W   = 25;
	localparam int OFS_W   = 3;
	localparam int STAT_W  = 3;
	localparam int SLOT_W  = 6;

	localparam logic [1:0] KIND_ACQUIRE = 2'd0;
	localparam logic [1:0] KIND_MARK    = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
	localparam logic [STAT_W-1:0] ST_MISS     = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOFREE   = 3'd2;
	localparam logic [STAT_W-1:0] ST_SHARED   = 3'd3;
	localparam logic [STAT_W-1:0] ST_CLEAN    = 3'd4;
	localparam logic [STAT_W-1:0] ST_WRITEBK  = 3'd5;
	localparam logic [STAT_W-1:0] ST_UNUSED   = 3'd6;

	localparam logic [SHARE_W-1:0] SHARE_MAX = 8'd255;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ACT,
		S_ADDR,
		S_OUT
	} state_t;

	// command broadcast to every cell
	typedef struct packed {
		logic                 match;   // compare tags this cycle
		logic                 hit_inc; // raise share of selected cell
		logic                 alloc;   // write tag into selected cell
		logic                 mark;    // set dirty of selected cell
		logic                 dec;     // lower share of selected cell
		logic [DEV_W-1:0]     device;
		logic [INODE_W-1:0]   inode;
	} cell_cmd_t;

endpackage

// ===== sv/icr_cell.sv =====
// one inode slot: tag, share count, dirty, valid, and a link in the hit chain
// depends on icr_pkg and assert_macros.svh
module icr_cell
	import icr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cell_cmd_t          cmd,
	input  logic               sel,       // this cell is the target of an update
	input  logic               found_in,  // a lower cell already matched
	output logic               found_out,
	output logic               hit,       // first matching cell
	output logic               valid,
	output logic               dirty,
	output logic [SHARE_W-1:0] share,
	output logic [INODE_W-1:0] inode
);

	logic               valid_q, dirty_q;
	logic [SHARE_W-1:0] share_q;
	logic [DEV_W-1:0]   dev_q;
	logic [INODE_W-1:0] inode_q;
	logic               tag_eq;

	// match along the chain
	assign tag_eq    = valid_q && dev_q == cmd.device && inode_q == cmd.inode;
	assign hit       = tag_eq && !found_in;
	assign found_out = found_in || tag_eq;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			share_q <= '0;
		end else if (sel) begin
			if (cmd.alloc) begin
				valid_q <= 1'b1;
				dirty_q <= 1'b0;
				share_q <= SHARE_W'(1);
			end else if (cmd.hit_inc) begin
				if (share_q != SHARE_MAX)
					share_q <= share_q + 1'b1;
			end else if (cmd.mark) begin
				dirty_q <= 1'b1;
			end else if (cmd.dec) begin
				if (share_q <= SHARE_W'(1)) begin
					share_q <= '0;
					valid_q <= 1'b0;
					dirty_q <= 1'b0;
				end else
					share_q <= share_q - 1'b1;
			end
		end
	end

	// tag payload
	always_ff @(posedge clk) begin
		if (sel && cmd.alloc) begin
			dev_q   <= cmd.device;
			inode_q <= cmd.inode;
		end
	end

	assign valid = valid_q;
	assign dirty = dirty_q;
	assign share = share_q;
	assign inode = inode_q;

	`include "assert_macros.svh"
	`ASSERT_CLK(a_dirty_valid, clk, arst_n, dirty_q |-> valid_q, "dirty cell not valid")
	`ASSERT_CLK(a_share_valid, clk, arst_n, (share_q != '0) |-> valid_q, "share on free cell")
	`ASSERT_CLK(a_alloc_free, clk, arst_n, (sel && cmd.alloc) |-> !valid_q, "alloc of used cell")

endmodule

// ===== sv/inode_cache_refcount.sv =====
// Inode cache with share counts: SLOTS cells in a chain, each holding one slot's
// tag and count; each item passes through accept, scan of the cell chain, update,
// address add and output, and may wait in output while the receiver stalls; free
// slots come from a LIFO register stack.
// depends on icr_pkg, icr_cell and assert_macros.svh
module inode_cache_refcount
	import icr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // kind
	input  logic [39:0] s_tdata,   // device[7:0], inode_number[31:8], slot[37:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [2:0]  m_tuser,   // status
	output logic [111:0] m_tdata   // result_slot, block_number, block_offset,
	                               // share_now, hit_total, miss_total
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TW = $clog2(SLOTS + 1);
	localparam int IPB_SH = $clog2(INODES_PER_BLOCK);

	state_t state_q, state_nx;

	logic [INODE_W-1:0] tbl_start_q;
	logic [1:0]         kind_q;
	logic [DEV_W-1:0]   dev_q;
	logic [INODE_W-1:0] ino_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               found_q;
	logic [SW-1:0]      hit_idx_q;
	logic [SW-1:0]      tgt_q;
	logic [STAT_W-1:0]  stat_q;
	logic [SLOT_W-1:0]  rslot_q;
	logic [SHARE_W-1:0] share_q;
	logic [INODE_W-1:0] idx_q;
	logic               addr_en_q;
	logic [BLK_W-1:0]   blk_q;
	logic [OFS_W-1:0]   ofs_q;
	logic [CNT_W-1:0]   hits_q, misses_q;
	logic [SW-1:0]      stack_q [SLOTS];
	logic [TW-1:0]      top_q;

	cell_cmd_t          cmd;
	logic [SLOTS-1:0]   sel, hit_v, valid_v, dirty_v;
	logic [SLOTS:0]     chain;
	logic [SHARE_W-1:0] share_v [SLOTS];
	logic [INODE_W-1:0] inode_v [SLOTS];
	logic [SW-1:0]      hit_enc;
	logic               slot_ok;
	logic [SW-1:0]      slot_idx;
	logic               apb_wr;

	// config port
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite && paddr == 2'd0;
	assign prdata = (paddr == 2'd0) ? {8'd0, tbl_start_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tbl_start_q <= '0;
		else if (apb_wr) tbl_start_q <= pwdata[INODE_W-1:0];
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_nx = S_SCAN;
			S_SCAN: state_nx = S_ACT;
			S_ACT:  state_nx = S_ADDR;
			S_ADDR: state_nx = S_OUT;
			S_OUT:  if (m_tready) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			S_IDLE:  s_tready = 1'b1;
			S_OUT:   m_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

	// cell chain
	assign slot_idx = slot_q[SW-1:0];
	assign slot_ok  = ({1'b0, slot_q} < (SLOT_W+1)'(SLOTS)) && valid_v[slot_idx];

	always_comb begin
		cmd = '0;
		cmd.device = dev_q;
		cmd.inode  = ino_q;
		if (state_q == S_ACT) begin
			case (kind_q)
				KIND_ACQUIRE: begin
					cmd.hit_inc = found_q;
					cmd.alloc   = !found_q && top_q != '0;
				end
				KIND_MARK:    cmd.mark = slot_ok;
				KIND_RELEASE: cmd.dec  = slot_ok;
				default: ;
			endcase
		end
	end

	always_comb begin
		sel = '0;
		if (kind_q == KIND_ACQUIRE) sel[found_q ? hit_idx_q : tgt_q] = 1'b1;
		else sel[slot_idx] = 1'b1;
	end

	assign chain[0] = 1'b0;
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		icr_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .sel(sel[g]),
			.found_in(chain[g]), .found_out(chain[g+1]), .hit(hit_v[g]),
			.valid(valid_v[g]), .dirty(dirty_v[g]), .share(share_v[g]),
			.inode(inode_v[g])
		);
	end

	always_comb begin
		hit_enc = '0;
		for (int i = 0; i < SLOTS; i++)
			if (hit_v[i]) hit_enc = SW'(i);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			dev_q  <= s_tdata[7:0];
			ino_q  <= s_tdata[31:8];
			slot_q <= s_tdata[37:32];
		end
		if (state_q == S_SCAN) begin
			found_q   <= chain[SLOTS];
			hit_idx_q <= hit_enc;
			tgt_q     <= (top_q != '0) ? stack_q[top_q[SW-1:0] - 1'b1] : '0;
		end
		if (state_q == S_ACT) begin
			stat_q    <= ST_UNUSED;
			rslot_q   <= '0;
			share_q   <= '0;
			idx_q     <= '0;
			addr_en_q <= 1'b0;
			case (kind_q)
				KIND_ACQUIRE: begin
					idx_q <= ino_q - 1'b1;
					if (found_q) begin
						stat_q    <= ST_HIT;
						rslot_q   <= SLOT_W'(hit_idx_q);
						share_q   <= (share_v[hit_idx_q] == SHARE_MAX) ? SHARE_MAX
						             : share_v[hit_idx_q] + 1'b1;
						addr_en_q <= 1'b1;
					end else if (top_q != '0) begin
						stat_q    <= ST_MISS;
						rslot_q   <= SLOT_W'(tgt_q);
						share_q   <= SHARE_W'(1);
						addr_en_q <= 1'b1;
					end else
						stat_q <= ST_NOFREE;
				end
				KIND_MARK, KIND_RELEASE: begin
					rslot_q <= slot_q;
					idx_q   <= inode_v[slot_idx] - 1'b1;
					if (slot_ok) begin
						addr_en_q <= 1'b1;
						if (kind_q == KIND_MARK) begin
							stat_q  <= ST_SHARED;
							share_q <= share_v[slot_idx];
						end else if (share_v[slot_idx] > SHARE_W'(1)) begin
							stat_q  <= ST_SHARED;
							share_q <= share_v[slot_idx] - 1'b1;
						end else
							stat_q <= dirty_v[slot_idx] ? ST_WRITEBK : ST_CLEAN;
					end
				end
				default: ;
			endcase
		end
		// address add
		if (state_q == S_ADDR) begin
			if (addr_en_q) begin
				blk_q <= BLK_W'(idx_q >> IPB_SH) + BLK_W'(tbl_start_q);
				ofs_q <= OFS_W'(idx_q & INODE_W'(INODES_PER_BLOCK - 1));
			end else begin
				blk_q <= '0;
				ofs_q <= '0;
			end
		end
	end

	// counters and free stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
			top_q    <= TW'(SLOTS);
			for (int i = 0; i < SLOTS; i++) stack_q[i] <= SW'(SLOTS - 1 - i);
		end else if (state_q == S_ACT) begin
			if (kind_q == KIND_ACQUIRE) begin
				if (found_q) hits_q <= hits_q + 1'b1;
				else begin
					misses_q <= misses_q + 1'b1;
					if (top_q != '0) top_q <= top_q - 1'b1;
				end
			end else if (kind_q == KIND_RELEASE && slot_ok
			             && share_v[slot_idx] <= SHARE_W'(1) && top_q < TW'(SLOTS)) begin
				stack_q[top_q[SW-1:0]] <= slot_idx;
				top_q <= top_q + 1'b1;
			end
		end
	end

	assign m_tuser = stat_q;
	assign m_tdata = {6'b000000, misses_q, hits_q, share_q, ofs_q, blk_q, rslot_q};

	`include "assert_macros.svh"
	`ASSERT_CLK(a_top_range, clk, arst_n, top_q <= TW'(SLOTS), "free stack overflow")
	`ASSERT_CLK(a_one_hit, clk, arst_n, $onehot0(hit_v), "more than one hit")
	`ASSERT_CLK(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> m_tvalid,
		"result dropped")

endmodule

// ===== sim/icr_checker.sv =====
// checker for the inode cache: watches both streams and the config port,
// predicts each result word and compares it field by field
// depends on icr_pkg
`timescale 1ns / 1ps
module icr_checker
	import icr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [1:0]   s_tuser,
	input  logic [39:0]  s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [2:0]   m_tuser,
	input  logic [111:0] m_tdata,
	output int           fail_count,
	output int           pending,
	output int           seen_total
);

	localparam int NSLOT = 64;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [SLOT_W-1:0]  slot;
		logic [BLK_W-1:0]   blk;
		logic [OFS_W-1:0]   ofs;
		logic [SHARE_W-1:0] share;
		logic [CNT_W-1:0]   hits;
		logic [CNT_W-1:0]   misses;
	} outcome_t;

	// shadow copy of the cache state
	logic [23:0]        table_start;
	logic               c_valid [NSLOT];
	logic [DEV_W-1:0]   c_dev   [NSLOT];
	logic [INODE_W-1:0] c_ino   [NSLOT];
	logic [SHARE_W-1:0] c_share [NSLOT];
	logic               c_dirty [NSLOT];
	logic [SLOT_W-1:0]  free_lifo [NSLOT];
	int                 free_cnt;
	logic [CNT_W-1:0]   hit_cnt, miss_cnt;
	outcome_t           expected_q [$];

	function automatic void locate(input logic [INODE_W-1:0] ino, inout outcome_t o);
		logic [INODE_W-1:0] idx;
		idx = ino - 1'b1;
		o.blk = BLK_W'(idx / 8) + BLK_W'(table_start);
		o.ofs = idx[2:0];
	endfunction

	function automatic outcome_t cache_op(input logic [1:0] kind, input logic [7:0] dev,
			input logic [23:0] ino, input logic [5:0] s);
		outcome_t o;
		int found;
		int n;
		o = '0;
		o.status = ST_UNUSED;
		found = -1;
		if (kind == KIND_ACQUIRE) begin
			for (int i = NSLOT - 1; i >= 0; i--)
				if (c_valid[i] && c_dev[i] == dev && c_ino[i] == ino) found = i;
			if (found >= 0) begin
				if (c_share[found] != SHARE_MAX) c_share[found]++;
				hit_cnt++;
				o.status = ST_HIT;
				o.slot = SLOT_W'(found);
				locate(ino, o);
				o.share = c_share[found];
			end else begin
				miss_cnt++;
				if (free_cnt == 0) begin
					o.status = ST_NOFREE;
				end else begin
					free_cnt--;
					n = free_lifo[free_cnt];
					c_valid[n] = 1; c_dev[n] = dev; c_ino[n] = ino;
					c_share[n] = 1; c_dirty[n] = 0;
					o.status = ST_MISS;
					o.slot = SLOT_W'(n);
					locate(ino, o);
					o.share = 1;
				end
			end
		end else if (kind == KIND_MARK || kind == KIND_RELEASE) begin
			o.slot = s;
			if (c_valid[s]) begin
				locate(c_ino[s], o);
				if (kind == KIND_MARK) begin
					c_dirty[s] = 1;
					o.status = ST_SHARED;
					o.share = c_share[s];
				end else begin
					if (c_share[s] != 0) c_share[s]--;
					if (c_share[s] != 0) begin
						o.status = ST_SHARED;
						o.share = c_share[s];
					end else begin
						o.status = c_dirty[s] ? ST_WRITEBK : ST_CLEAN;
						c_valid[s] = 0;
						c_dirty[s] = 0;
						if (free_cnt < NSLOT) begin
							free_lifo[free_cnt] = s;
							free_cnt++;
						end
					end
				end
			end
		end
		o.hits = hit_cnt;
		o.misses = miss_cnt;
		return o;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		outcome_t got, want;
		if (!arst_n) begin
			table_start = '0;
			for (int i = 0; i < NSLOT; i++) begin
				c_valid[i] = 0; c_dev[i] = 0; c_ino[i] = 0;
				c_share[i] = 0; c_dirty[i] = 0;
				free_lifo[i] = SLOT_W'(NSLOT - 1 - i);
			end
			free_cnt = NSLOT;
			hit_cnt = 0;
			miss_cnt = 0;
			expected_q.delete();
			fail_count = 0;
			seen_total = 0;
		end else begin
			// result word against oldest expectation
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[5:0], m_tdata[30:6], m_tdata[33:31],
					m_tdata[41:34], m_tdata[73:42], m_tdata[105:74]};
				seen_total++;
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result word %h", $time, got);
				end else begin
					want = expected_q.pop_front();
					if (got.status !== want.status || got.slot !== want.slot ||
							got.blk !== want.blk || got.ofs !== want.ofs ||
							got.share !== want.share || got.hits !== want.hits ||
							got.misses !== want.misses) begin
						fail_count++;
						$display("%0t: mismatch expected st=%0d slot=%0d blk=%0d ofs=%0d sh=%0d hit=%0d miss=%0d",
							$time, want.status, want.slot, want.blk, want.ofs,
							want.share, want.hits, want.misses);
						$display("%0t:          actual   st=%0d slot=%0d blk=%0d ofs=%0d sh=%0d hit=%0d miss=%0d",
							$time, got.status, got.slot, got.blk, got.ofs,
							got.share, got.hits, got.misses);
					end
				end
			end
			// register write
			if (psel && penable && pwrite && pready && paddr == 2'd0)
				table_start = pwdata[23:0];
			// accepted input word
			if (s_tvalid && s_tready)
				expected_q.push_back(cache_op(s_tuser, s_tdata[7:0], s_tdata[31:8],
					s_tdata[37:32]));
		end
	end

endmodule

// ===== sim/tb.sv =====
// testbench top for the inode cache: clock, reset, stimulus and verdict
// depends on icr_pkg, inode_cache_refcount and icr_checker
`timescale 1ns / 1ps
module tb;
	import icr_pkg::*;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         psel = 0, penable = 0, pwrite = 0;
	logic [1:0]   paddr = 0;
	logic [31:0]  pwdata = 0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [1:0]   s_tuser = 0;  // kind
	logic [39:0]  s_tdata = 0;  // device, inode_number, slot, pad
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [2:0]   m_tuser;      // status
	logic [111:0] m_tdata;      // result_slot, block_number, block_offset, share, hits, misses
	int           fail_count, pending, seen_total;
	int           sent;
	bit           hold_long = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	inode_cache_refcount u_top (.*);

	icr_checker u_chk (.*);

	// small pool of tags so acquires hit often
	logic [7:0]  dev_pool [8];
	logic [23:0] ino_pool [8];

	task automatic reg_write(input logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 2'd0; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_word(input logic [1:0] kind, input logic [7:0] dev,
			input logic [23:0] ino, input logic [5:0] s);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
			(($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {2'b00, s, ino, dev};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic drain;
		int guard;
		s_tvalid <= 0;
		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic random_word;
		int r, p;
		r = $urandom_range(0, 99);
		p = $urandom_range(0, 7);
		if (r < 40) send_word(KIND_ACQUIRE, dev_pool[p], ino_pool[p], 6'($urandom));
		else if (r < 50)
			send_word(KIND_ACQUIRE, 8'($urandom), 24'($urandom), 6'($urandom));
		else if (r < 62)
			send_word(KIND_MARK, 8'($urandom), 24'($urandom), 6'($urandom_range(0, 63)));
		else if (r < 97)
			send_word(KIND_RELEASE, 8'($urandom), 24'($urandom), 6'($urandom_range(0, 63)));
		else send_word(2'd3, 8'($urandom), 24'($urandom), 6'($urandom));
	endtask

	// receiver back-pressure
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				hold_long = 0;
			end
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
				(($urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : 0);
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		logic [31:0] starts [4];
		starts[0] = 32'h0; starts[1] = 32'hFFFFFF; starts[2] = 32'h123456;
		starts[3] = 32'h800000;
		sent = 0;
		for (int i = 0; i < 8; i++) begin
			dev_pool[i] = 8'($urandom);
			ino_pool[i] = 24'($urandom);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every kind, inode zero, unused slot, unknown kind
		reg_write(32'hFFFFFF);
		send_word(KIND_ACQUIRE, 8'hFF, 24'hFFFFFF, 6'h3F);
		send_word(KIND_ACQUIRE, 8'h00, 24'h000001, 6'h00);
		send_word(KIND_ACQUIRE, 8'h00, 24'h000000, 6'h00);
		send_word(KIND_ACQUIRE, 8'hFF, 24'hFFFFFF, 6'h00);
		send_word(KIND_MARK, 8'h00, 24'h000000, 6'd0);
		send_word(KIND_MARK, 8'hFF, 24'hFFFFFF, 6'd63);
		send_word(KIND_RELEASE, 8'hFF, 24'hFFFFFF, 6'd63);
		send_word(KIND_RELEASE, 8'h00, 24'h000000, 6'd0);
		send_word(KIND_RELEASE, 8'h00, 24'h000000, 6'd0);
		send_word(KIND_RELEASE, 8'h00, 24'h000000, 6'd1);
		send_word(KIND_RELEASE, 8'h00, 24'h000000, 6'd2);
		send_word(2'd3, 8'hAA, 24'h555555, 6'h2A);
		// share saturation on one tag
		for (int i = 0; i < 260; i++) send_word(KIND_ACQUIRE, 8'h5A, 24'hA5A5A5, 6'd0);
		// fill the table, then no free slot
		for (int i = 0; i < 66; i++) send_word(KIND_ACQUIRE, 8'h11, 24'(i + 100), 6'd0);
		for (int i = 0; i < 64; i++) send_word(KIND_RELEASE, 8'h00, 24'h000000, 6'(i));
		drain();

		// random phases over several table starts, one long receiver stall
		for (int ph = 0; ph < 4; ph++) begin
			reg_write(starts[ph]);
			if (ph == 1) hold_long = 1;
			repeat (370) random_word();
			drain();
		end

		$display("covered %0d input words, %0d result words, four table starts,",
			sent, seen_total);
		$display("share saturation, full table and long output stall");
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/icr_pkg.sv
sv/icr_cell.sv
sv/inode_cache_refcount.sv
sim/icr_checker.sv
sim/tb.sv
